// ===== rtl/core/upw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upw_pkg
// Shared types, constants and helpers for the user page-table walker.
// ----------------------------------------------------------------------------
package upw_pkg;

    localparam int PHYS_ADDR_BITS = 52;
    localparam int PA_W           = 52;   // fixed width of the address ports
    localparam int VA_W           = 64;
    localparam int PTE_W          = 64;
    localparam int CFG_IDX_W      = 2;

    typedef logic [PA_W-1:0]      t_paddr;
    typedef logic [VA_W-1:0]      t_vaddr;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [2:0]           t_level;

    // configuration register indexes
    localparam t_cfg_idx CFG_USER_BASE  = 2'd0;
    localparam t_cfg_idx CFG_USER_LIMIT = 2'd1;
    localparam t_cfg_idx CFG_ROOT_TABLE = 2'd2;

    // walk levels
    localparam t_level LVL_IDLE = 3'd0;
    localparam t_level LVL_1    = 3'd1;
    localparam t_level LVL_2    = 3'd2;
    localparam t_level LVL_3    = 3'd3;
    localparam t_level LVL_4    = 3'd4;

    // input commands and result kinds
    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;
    localparam logic KIND_READ    = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    // entry bits
    localparam int PTE_PRESENT = 0;
    localparam int PTE_WRITE   = 1;
    localparam int PTE_USER    = 2;
    localparam int PTE_HUGE    = 7;

    localparam t_paddr PHYS_MASK  = (t_paddr'(1) << PHYS_ADDR_BITS) - t_paddr'(1);
    localparam t_paddr FRAME_MASK = 52'hF_FFFF_FFFF_F000 & PHYS_MASK;
    localparam int     PAGE_OFS_W = 12;

    typedef struct packed {
        t_vaddr user_base;
        t_vaddr user_limit;
        t_paddr root_table;
    } t_cfg;

    typedef struct packed {
        t_level level;
        t_vaddr held_addr;
        logic   held_wr;
    } t_walk_state;

    typedef struct packed {
        logic   emit;
        logic   kind;
        t_paddr read_addr;
        logic   ok;
        t_paddr phys_addr;
    } t_result;

    // 9-bit table index for a level; sel is level minus one
    function automatic logic [8:0] level_index(t_vaddr va, logic [1:0] sel);
        logic [8:0] idx;
        case (sel)
            2'd0:    idx = va[20:12];
            2'd1:    idx = va[29:21];
            2'd2:    idx = va[38:30];
            default: idx = va[47:39];
        endcase
        return idx;
    endfunction

    // table base plus index times eight, wrapped to the physical width
    function automatic t_paddr entry_addr(t_paddr base, logic [8:0] idx);
        t_paddr sum;
        sum = base + t_paddr'({idx, 3'b000});
        return sum & PHYS_MASK;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/upw_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upw_cfg
// Configuration register file: user window bounds and root table address.
// ----------------------------------------------------------------------------
module upw_cfg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire upw_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [63:0]       i_cfg_data,
    output upw_pkg::t_cfg          o_cfg
);

    upw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                upw_pkg::CFG_USER_BASE:  r_cfg.user_base  <= i_cfg_data;
                upw_pkg::CFG_USER_LIMIT: r_cfg.user_limit <= i_cfg_data;
                upw_pkg::CFG_ROOT_TABLE: r_cfg.root_table <= i_cfg_data[51:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/core/upw_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upw_step
// One walk step: checks a start or a returned entry and forms the next
// request or the final translation, with the next walk state.
// ----------------------------------------------------------------------------
module upw_step (
    input  wire upw_pkg::t_cfg        i_cfg,
    input  wire upw_pkg::t_walk_state i_state,
    input  wire logic                 i_command,
    input  wire logic [63:0]          i_virtual_address,
    input  wire logic                 i_write_check,
    input  wire logic [63:0]          i_table_entry,
    output upw_pkg::t_walk_state      o_next,
    output upw_pkg::t_result          o_res
);

    upw_pkg::t_paddr frame;
    logic            perm_ok;
    logic [1:0]      next_sel;

    assign frame    = i_table_entry[51:0] & upw_pkg::FRAME_MASK;
    assign perm_ok  = i_table_entry[upw_pkg::PTE_PRESENT] & i_table_entry[upw_pkg::PTE_USER];
    assign next_sel = 2'(i_state.level - 3'd2);

    always_comb begin
        o_next = i_state;
        o_res  = '0;
        if (i_command == upw_pkg::CMD_START) begin
            o_next.held_addr = i_virtual_address;
            o_next.held_wr   = i_write_check;
            o_res.emit       = 1'b1;
            if (i_cfg.root_table == '0 || i_virtual_address < i_cfg.user_base ||
                i_virtual_address >= i_cfg.user_limit) begin
                o_next.level = upw_pkg::LVL_IDLE;
                o_res.kind   = upw_pkg::KIND_DONE;
            end else begin
                o_next.level    = upw_pkg::LVL_4;
                o_res.kind      = upw_pkg::KIND_READ;
                o_res.read_addr = upw_pkg::entry_addr(i_cfg.root_table,
                                      upw_pkg::level_index(i_virtual_address, 2'd3));
            end
        end else begin
            case (i_state.level)
                upw_pkg::LVL_2, upw_pkg::LVL_3, upw_pkg::LVL_4: begin
                    o_res.emit = 1'b1;
                    if (!perm_ok || i_table_entry[upw_pkg::PTE_HUGE]) begin
                        o_next.level = upw_pkg::LVL_IDLE;
                        o_res.kind   = upw_pkg::KIND_DONE;
                    end else begin
                        o_next.level    = i_state.level - 3'd1;
                        o_res.kind      = upw_pkg::KIND_READ;
                        o_res.read_addr = upw_pkg::entry_addr(frame,
                                              upw_pkg::level_index(i_state.held_addr,
                                                                   next_sel));
                    end
                end
                upw_pkg::LVL_1: begin
                    o_res.emit   = 1'b1;
                    o_res.kind   = upw_pkg::KIND_DONE;
                    o_next.level = upw_pkg::LVL_IDLE;
                    if (perm_ok && (!i_state.held_wr || i_table_entry[upw_pkg::PTE_WRITE])) begin
                        o_res.ok        = 1'b1;
                        o_res.phys_addr = (frame | upw_pkg::t_paddr'(
                                              i_state.held_addr[upw_pkg::PAGE_OFS_W-1:0]))
                                          & upw_pkg::PHYS_MASK;
                    end
                end
                default: begin
                    // idle or stray level: response dropped
                    o_next.level = upw_pkg::LVL_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/user_page_table_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// user_page_table_walker
// Four-level page-table walker for user virtual addresses.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    command, address, flag, entry
//   result    out        o_out_valid / i_out_ready  kind, read/phys address, ok
//   config    in         i_cfg_valid / o_cfg_ready  index, data
//
// Each transaction is handled in the cycle it is accepted; its result, if any,
// appears in the output register on the next cycle. One transaction per cycle
// is sustained while the result side keeps up; the single output register
// sets the figure. Synchronous active-low reset clears the walk state, the
// configuration and the output valid. A stalled result holds the input off.
// ----------------------------------------------------------------------------
module user_page_table_walker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic         i_command,
    input  wire logic [63:0]  i_virtual_address,
    input  wire logic         i_write_check,
    input  wire logic [63:0]  i_table_entry,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic              o_result_kind,
    output logic [51:0]       o_read_address,
    output logic              o_translation_ok,
    output logic [51:0]       o_physical_address,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);

    upw_pkg::t_cfg        cfg;
    upw_pkg::t_walk_state r_state, n_state;
    upw_pkg::t_result     step_res;
    upw_pkg::t_result     r_res;
    logic                 r_out_valid;
    logic                 accept;

    assign o_cfg_ready = 1'b1;

    upw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    upw_step u_step (
        .i_cfg             (cfg),
        .i_state           (r_state),
        .i_command         (i_command),
        .i_virtual_address (i_virtual_address),
        .i_write_check     (i_write_check),
        .i_table_entry     (i_table_entry),
        .o_next            (n_state),
        .o_res             (step_res)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept && step_res.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && step_res.emit) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_res.kind;
    assign o_read_address     = r_res.read_addr;
    assign o_translation_ok   = r_res.ok;
    assign o_physical_address = r_res.phys_addr;

endmodule
`default_nettype wire

// ===== verif/user_page_table_walker_test.sv =====
// ----------------------------------------------------------------------------
// user_page_table_walker_test
// Self-checking bench for the four-level user page-table walker. Starts and
// table-entry responses are driven with random bursts and gaps while the
// result side stalls on its own pattern. A local walk predictor, fed by every
// accepted input transaction, queues the expected read requests and finished
// translations; each result transaction is checked field by field in order.
// ----------------------------------------------------------------------------
module user_page_table_walker_test;
    import upw_pkg::*;

    localparam int       WATCHDOG_LIMIT         = 4000;
    localparam int       RANDOM_PHASES          = 6;
    localparam int       WALK_RESULTS_PER_PHASE = 68;
    localparam t_cfg_idx CFG_SPARE              = 2'd3;   // decodes to no register

    typedef struct packed {
        logic   kind;
        t_paddr read_addr;
        logic   ok;
        t_paddr phys_addr;
    } walk_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [63:0] virtual_address;
    logic        write_check;
    logic [63:0] table_entry;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic        result_kind;
    logic [51:0] read_address;
    logic        translation_ok;
    logic [51:0] physical_address;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // predictor copy of configuration and walk state
    t_vaddr cfg_base      = '0;
    t_vaddr cfg_limit     = '0;
    t_paddr cfg_root      = '0;
    t_level walk_lvl      = LVL_IDLE;
    t_vaddr walk_va       = '0;
    logic   walk_wr_check = 1'b0;

    walk_result_t pending_walk_results[$];
    int walk_results_due = 0;
    int mismatches       = 0;
    int quiet_cycles     = 0;
    int send_burst_left  = 0;
    int stall_mode       = 0;
    int stall_mode_left  = 0;
    int stall_hold       = 0;

    user_page_table_walker dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_command          (command),
        .i_virtual_address  (virtual_address),
        .i_write_check      (write_check),
        .i_table_entry      (table_entry),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_result_kind      (result_kind),
        .o_read_address     (read_address),
        .o_translation_ok   (translation_ok),
        .o_physical_address (physical_address),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // entry address within a table for the given level of the held address
    function automatic t_paddr table_slot(t_paddr base, t_vaddr va, t_level lvl);
        logic [63:0] idx;
        idx = (va >> (12 + 9 * (int'(lvl) - 1))) & 64'h1ff;
        return (base + t_paddr'(idx << 3)) & PHYS_MASK;
    endfunction

    // advances the walk by one input transaction; returns 1 if a result follows
    function automatic logic predict_walk_step(input logic cmd, input t_vaddr va,
                                               input logic wr, input logic [63:0] pte,
                                               output walk_result_t res);
        t_paddr frame;
        res   = '0;
        frame = t_paddr'(pte) & FRAME_MASK;
        if (cmd == CMD_START) begin
            walk_va       = va;
            walk_wr_check = wr;
            if (cfg_root == '0 || va < cfg_base || va >= cfg_limit) begin
                walk_lvl = LVL_IDLE;
                res.kind = KIND_DONE;
                return 1'b1;
            end
            walk_lvl      = LVL_4;
            res.kind      = KIND_READ;
            res.read_addr = table_slot(cfg_root, va, LVL_4);
            return 1'b1;
        end
        if (walk_lvl < LVL_1 || walk_lvl > LVL_4) begin
            walk_lvl = LVL_IDLE;
            return 1'b0;
        end
        res.kind = KIND_DONE;
        if (!pte[PTE_PRESENT] || !pte[PTE_USER]) begin
            walk_lvl = LVL_IDLE;
        end else if (walk_lvl > LVL_1) begin
            if (pte[PTE_HUGE]) begin
                walk_lvl = LVL_IDLE;
            end else begin
                walk_lvl      = t_level'(walk_lvl - 3'd1);
                res.kind      = KIND_READ;
                res.read_addr = table_slot(frame, walk_va, walk_lvl);
            end
        end else begin
            walk_lvl = LVL_IDLE;
            if (!(walk_wr_check && !pte[PTE_WRITE])) begin
                res.ok        = 1'b1;
                res.phys_addr = (frame | t_paddr'(walk_va[11:0])) & PHYS_MASK;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
        mismatches++;
    endtask

    // result check first, so a stray result never meets an expectation queued
    // on the same edge
    always @(posedge clk) begin : monitor
        walk_result_t want;
        logic         hit;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_walk_results.size() == 0) begin
                    report_mismatch("result with nothing expected", result_kind, 64'h0);
                end else begin
                    want = pending_walk_results.pop_front();
                    if (result_kind !== want.kind)
                        report_mismatch("result_kind", result_kind, want.kind);
                    if (read_address !== want.read_addr)
                        report_mismatch("read_address", read_address, want.read_addr);
                    if (translation_ok !== want.ok)
                        report_mismatch("translation_ok", translation_ok, want.ok);
                    if (physical_address !== want.phys_addr)
                        report_mismatch("physical_address", physical_address,
                                        want.phys_addr);
                end
            end
            if (in_valid && in_ready) begin
                hit = predict_walk_step(command, virtual_address, write_check,
                                        table_entry, want);
                if (hit) begin
                    pending_walk_results.push_back(want);
                    walk_results_due++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_USER_BASE:  cfg_base  = cfg_data;
                    CFG_USER_LIMIT: cfg_limit = cfg_data;
                    CFG_ROOT_TABLE: cfg_root  = t_paddr'(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("user_page_table_walker_test: errors");
                    $finish;
                end
            end
        end
    end

    // result side: free-flowing, random, sparse, or long holds
    always @(negedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 200);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            0: out_ready = 1'b1;
            1: out_ready = 1'($urandom_range(0, 1));
            2: out_ready = ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_hold > 0) begin
                    stall_hold--;
                    out_ready = 1'b0;
                end else begin
                    out_ready = 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_hold = $urandom_range(1, 20);
                end
            end
        endcase
    end

    task automatic send_item(input logic cmd, input t_vaddr va, input logic wr,
                             input logic [63:0] pte);
        int gap;
        if (send_burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap) @(negedge clk);
            send_burst_left = $urandom_range(1, 30);
        end
        send_burst_left--;
        command         = cmd;
        virtual_address = va;
        write_check     = wr;
        table_entry     = pte;
        in_valid        = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic start_walk(input t_vaddr va, input logic wr);
        send_item(CMD_START, va, wr, rand64());
    endtask

    task automatic return_entry(input logic [63:0] pte);
        send_item(CMD_RESPONSE, rand64(), 1'($urandom_range(0, 1)), pte);
    endtask

    function automatic logic [63:0] make_entry(input logic present, input logic user,
                                               input logic huge, input logic writable);
        logic [63:0] e;
        e              = rand64();
        e[PTE_PRESENT] = present;
        e[PTE_USER]    = user;
        e[PTE_HUGE]    = huge;
        e[PTE_WRITE]   = writable;
        return e;
    endfunction

    function automatic t_vaddr window_address();
        if ($urandom_range(0, 9) != 0 && cfg_limit > cfg_base)
            return cfg_base + rand64() % (cfg_limit - cfg_base);
        return rand64();
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        while (pending_walk_results.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // fault any open walk, drain, then reprogram
    task automatic set_window(input logic [63:0] base, input logic [63:0] limit,
                              input logic [63:0] root);
        while (walk_lvl != LVL_IDLE) return_entry(64'h0);
        settle();
        write_reg(CFG_USER_BASE, base);
        write_reg(CFG_USER_LIMIT, limit);
        write_reg(CFG_ROOT_TABLE, root);
    endtask

    task automatic test_no_address_space();
        // registers at reset: root is zero, window empty
        start_walk(64'h0, 1'b0);
        return_entry(64'hFFFF_FFFF_FFFF_FFFF);  // idle, no result
        start_walk(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    endtask

    task automatic test_user_window();
        logic [63:0] base;
        logic [63:0] limit;
        base  = 64'h0000_0000_0040_0000;
        limit = 64'h0000_7FFF_FFFF_F000;
        set_window(base, limit, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SPARE, rand64());
        start_walk(base - 64'd1, 1'b0);
        start_walk(base, 1'b1);
        start_walk(limit, 1'b0);                // abandons the open walk and faults
        set_window('1, '1, 64'h8);
        start_walk('1, 1'b0);
        set_window('0, '1, 64'h8);
        start_walk('1, 1'b1);                   // not below the limit
        start_walk('0, 1'b0);
    endtask

    task automatic test_table_walk();
        set_window('0, '1, 64'h000F_FFFF_FFFF_F000);
        // write-checked success; last entry all ones, page-size ignored there
        start_walk(rand64(), 1'b1);
        repeat (3) return_entry(make_entry(1'b1, 1'b1, 1'b0, 1'b1));
        return_entry('1);
        // write check on a read-only page
        start_walk(rand64(), 1'b1);
        repeat (3) return_entry(make_entry(1'b1, 1'b1, 1'b0, 1'b1));
        return_entry(make_entry(1'b1, 1'b1, 1'b0, 1'b0));
        // large page at an upper level
        start_walk(rand64(), 1'b0);
        return_entry(make_entry(1'b1, 1'b1, 1'b0, 1'b1));
        return_entry(make_entry(1'b1, 1'b1, 1'b1, 1'b1));
        start_walk(rand64(), 1'b0);
        return_entry(make_entry(1'b0, 1'b1, 1'b0, 1'b1));
        // restart mid-walk; the next entry belongs to the new walk
        start_walk(rand64(), 1'b1);
        return_entry(make_entry(1'b1, 1'b1, 1'b0, 1'b1));
        start_walk(rand64(), 1'b0);
        return_entry(make_entry(1'b1, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic random_sequence();
        int pick;
        int steps;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            start_walk(window_address(), 1'($urandom_range(0, 1)));
            steps = 0;
            while (walk_lvl != LVL_IDLE && steps < 6) begin
                pick = $urandom_range(0, 99);
                if (pick < 90)
                    return_entry(make_entry(1'b1, 1'b1,
                                 (walk_lvl == LVL_1) ? 1'($urandom_range(0, 1)) : 1'b0,
                                 $urandom_range(0, 4) != 0));
                else if (pick < 95)
                    start_walk(window_address(), 1'($urandom_range(0, 1)));
                else
                    return_entry(rand64());
                steps++;
            end
        end else if (pick < 90) begin
            send_item(1'($urandom_range(0, 1)), rand64(), 1'($urandom_range(0, 1)),
                      rand64());
        end else begin
            start_walk(rand64(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_walks();
        int          goal;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] root;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            a    = rand64();
            b    = rand64();
            root = ($urandom_range(0, 7) == 0) ? '1 : rand64();
            case ($urandom_range(0, 5))
                0, 1: begin
                    a = '0;
                    b = '1;
                end
                2: {a, b} = (a > b) ? {b, a} : {a, b};
                3: b = a + 64'($urandom_range(0, 32'h000F_FFFF));
                4: b = a;
                default: begin
                    a = '0;
                    b = '1;
                    if ($urandom_range(0, 1) == 0) root = '0;
                end
            endcase
            set_window(a, b, root);
            goal = walk_results_due + WALK_RESULTS_PER_PHASE;
            while (walk_results_due < goal) random_sequence();
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        command         = CMD_START;
        virtual_address = '0;
        write_check     = 1'b0;
        table_entry     = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_USER_BASE;
        cfg_data        = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_no_address_space();
        test_user_window();
        test_table_walk();
        test_random_walks();
        settle();

        if (mismatches == 0)
            $display("user_page_table_walker_test: clean");
        else
            $display("user_page_table_walker_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/upw_pkg.sv
rtl/core/upw_cfg.sv
rtl/core/upw_step.sv
rtl/core/user_page_table_walker.sv
verif/user_page_table_walker_test.sv
